### hdl/gps_synced_flash_phase_timer_unit_assert.svh
// ----------------------------------------------------------------------------
// gps synced flash phase timer assertion macros
// shared assertion forms, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef GPS_SYNCED_FLASH_PHASE_TIMER_UNIT_ASSERT_SVH
`define GPS_SYNCED_FLASH_PHASE_TIMER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define GSFPT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GSFPT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define GSFPT_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define GSFPT_ASSERT_NXT(label, clk, rst, ante, cons, msg)

`endif

`endif

### hdl/gsfpt_pkg.sv
// ----------------------------------------------------------------------------
// gsfpt_pkg
// widths, codes, constants and shared types of the flash phase timer
// ----------------------------------------------------------------------------
`default_nettype none

package gsfpt_pkg;

  // field widths
  localparam int MS_W      = 10;
  localparam int SEC_W     = 6;
  localparam int MIN_W     = 6;
  localparam int HOUR_W    = 5;
  localparam int DAY_W     = 27;
  localparam int SUM_W     = 28;
  localparam int PHASE_W   = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  // modulo unit sizing
  localparam int DIV_STEPS = SUM_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // day base multiply-accumulate sizing
  localparam int MAC_OP_W   = 6;
  localparam int MAC_WGT_W  = 22;
  localparam int MAC_PROD_W = MAC_OP_W + MAC_WGT_W;

  // operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CYCLE_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ON_DUTY      = 1'b1;

  // register reset values
  localparam logic [CFG_W-1:0] CYCLE_LENGTH_RESET = 16'd1000;
  localparam logic [CFG_W-1:0] ON_DUTY_RESET      = 16'd500;

  // time keeping constants
  localparam logic [MS_W-1:0]   MS_LAST       = 10'd999;
  localparam logic [MS_W:0]     MS_PER_SEC    = 11'd1000;
  localparam logic [SEC_W:0]    SEC_PER_MIN   = 7'd60;
  localparam logic [MIN_W:0]    MIN_PER_HOUR  = 7'd60;
  localparam logic [HOUR_W:0]   HOURS_PER_DAY = 6'd24;
  localparam logic [SEC_W-1:0]  SYNC_SECOND   = 6'd59;

  // day base weights in milliseconds
  localparam logic [MAC_WGT_W-1:0] WGT_HOUR   = 22'd3600000;
  localparam logic [MAC_WGT_W-1:0] WGT_MINUTE = 22'd60000;
  localparam logic [MAC_WGT_W-1:0] WGT_SECOND = 22'd1000;

  // multiply-accumulate step codes
  localparam logic [1:0] MAC_HOUR   = 2'd0;
  localparam logic [1:0] MAC_MINUTE = 2'd1;
  localparam logic [1:0] MAC_SECOND = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_LAUNCH,
    ST_DIV,
    ST_PHASE,
    ST_EMIT
  } gsfpt_state_t;

  // request into the modulo unit
  typedef struct packed {
    logic               start;
    logic [SUM_W-1:0]   dividend;
    logic [PHASE_W-1:0] divisor;
  } gsfpt_mod_req_t;

  // status out of the modulo unit
  typedef struct packed {
    logic               busy;
    logic               done;
    logic [PHASE_W-1:0] remainder;
  } gsfpt_mod_rsp_t;

  // weight for one step of the day base sum
  function automatic logic [MAC_WGT_W-1:0] mac_weight(input logic [1:0] step);
    logic [MAC_WGT_W-1:0] w;
    case (step)
      MAC_HOUR:   w = WGT_HOUR;
      MAC_MINUTE: w = WGT_MINUTE;
      MAC_SECOND: w = WGT_SECOND;
      default:    w = '0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### hdl/gsfpt_if.sv
// ----------------------------------------------------------------------------
// gsfpt_if
// valid/ready channels carrying input items and result items
// ----------------------------------------------------------------------------
`default_nettype none

interface gsfpt_item_if
  import gsfpt_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic              pps_level;
  logic [HOUR_W-1:0] gps_hour;
  logic [MIN_W-1:0]  gps_minute;
  logic [SEC_W-1:0]  gps_second;

  modport source (output valid, operation, pps_level, gps_hour, gps_minute, gps_second,
                  input ready);
  modport sink   (input valid, operation, pps_level, gps_hour, gps_minute, gps_second,
                  output ready);
endinterface

interface gsfpt_result_if
  import gsfpt_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic               lamp_on;
  logic [PHASE_W-1:0] phase_ms;
  logic [HOUR_W-1:0]  clock_hour;
  logic [MIN_W-1:0]   clock_minute;
  logic [SEC_W-1:0]   clock_second;
  logic [MS_W-1:0]    clock_millis;

  modport source (output valid, lamp_on, phase_ms, clock_hour, clock_minute, clock_second,
                  clock_millis, input ready);
  modport sink   (input valid, lamp_on, phase_ms, clock_hour, clock_minute, clock_second,
                  clock_millis, output ready);
endinterface

`default_nettype wire

### hdl/gps_synced_flash_phase_timer_unit.sv
// ----------------------------------------------------------------------------
// gps_synced_flash_phase_timer_unit
// millisecond time of day with gps second sync and flash phase output
// ----------------------------------------------------------------------------
// a tick transaction runs through ST_LAUNCH, ST_DIV on the 28-bit remainder unit,
// ST_PHASE and ST_EMIT; when the millisecond count wraps, ST_MAC first rebuilds the day base
// a load transaction goes from acceptance straight to ST_EMIT
// one transaction at a time: the next is accepted only back in ST_IDLE after ST_EMIT,
// later while the previous result waits for ready
// synchronous reset clears the clock, the stored gps time and the registers
`default_nettype none
`include "gps_synced_flash_phase_timer_unit_assert.svh"

module gps_synced_flash_phase_timer_unit
  import gsfpt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  gsfpt_item_if.sink                item,
  gsfpt_result_if.source            result
);

  gsfpt_state_t state, state_next;

  // configuration
  logic [CFG_W-1:0] cycle_length;
  logic [CFG_W-1:0] on_duty;

  // kept clock and gps time
  logic [MS_W-1:0]   millis_count;
  logic [SEC_W-1:0]  second_count;
  logic [MIN_W-1:0]  minute_count;
  logic [HOUR_W-1:0] hour_count;
  logic [DAY_W-1:0]  day_base_ms;
  logic              pps_previous;
  logic [HOUR_W-1:0] loaded_hour;
  logic [MIN_W-1:0]  loaded_minute;
  logic [SEC_W-1:0]  loaded_second;
  logic [PHASE_W-1:0] last_phase;
  logic              last_lamp;

  // next clock after a tick
  logic              sync;
  logic [MS_W-1:0]   base_ms;
  logic [SEC_W-1:0]  base_s;
  logic [MIN_W-1:0]  base_min;
  logic [HOUR_W-1:0] base_hour;
  logic [MS_W:0]     ms_inc;
  logic [SEC_W:0]    s_inc;
  logic [MIN_W:0]    min_inc;
  logic [HOUR_W:0]   hour_inc;
  logic [MS_W-1:0]   millis_next;
  logic [SEC_W-1:0]  second_next;
  logic [MIN_W-1:0]  minute_next;
  logic [HOUR_W-1:0] hour_next;

  // shared multiply-accumulate
  logic [1:0]            mac_step;
  logic [MAC_OP_W-1:0]   mac_operand;
  logic [MAC_PROD_W-1:0] mac_product;
  logic [DAY_W-1:0]      mac_acc;

  // phase
  logic [SUM_W-1:0]   sum;
  logic [PHASE_W-1:0] phase_val;

  // sequencer outputs
  logic accept;
  logic item_ready;
  logic mac_en;
  logic mod_start;
  logic phase_wr;
  logic emit;

  // output register
  logic               out_valid;
  logic               out_lamp;
  logic [PHASE_W-1:0] out_phase;
  logic [HOUR_W-1:0]  out_hour;
  logic [MIN_W-1:0]   out_minute;
  logic [SEC_W-1:0]   out_second;
  logic [MS_W-1:0]    out_millis;

  gsfpt_mod_req_t mod_req;
  gsfpt_mod_rsp_t mod_rsp;

  assign accept = item.valid && item_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_length <= CYCLE_LENGTH_RESET;
      on_duty      <= ON_DUTY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CYCLE_LENGTH: cycle_length <= cfg_data;
        REG_ON_DUTY:      on_duty      <= cfg_data;
      endcase
    end
  end

  // clock advance with pps sync
  always_comb begin
    sync = item.pps_level && !pps_previous && (loaded_second == SYNC_SECOND);
    base_ms   = sync ? MS_LAST       : millis_count;
    base_s    = sync ? loaded_second : second_count;
    base_min  = sync ? loaded_minute : minute_count;
    base_hour = sync ? loaded_hour   : hour_count;
    ms_inc   = {1'b0, base_ms} + 1'b1;
    s_inc    = {1'b0, base_s} + 1'b1;
    min_inc  = {1'b0, base_min} + 1'b1;
    hour_inc = {1'b0, base_hour} + 1'b1;
    millis_next = ms_inc[MS_W-1:0];
    second_next = base_s;
    minute_next = base_min;
    hour_next   = base_hour;
    if (ms_inc >= MS_PER_SEC) begin
      millis_next = '0;
      second_next = s_inc[SEC_W-1:0];
      if (s_inc >= SEC_PER_MIN) begin
        second_next = '0;
        minute_next = min_inc[MIN_W-1:0];
        if (min_inc >= MIN_PER_HOUR) begin
          minute_next = '0;
          hour_next   = hour_inc[HOUR_W-1:0];
          if (hour_inc >= HOURS_PER_DAY) begin
            hour_next = '0;
          end
        end
      end
    end
  end

  // clock and gps time registers
  always_ff @(posedge clk) begin
    if (rst) begin
      millis_count  <= '0;
      second_count  <= '0;
      minute_count  <= '0;
      hour_count    <= '0;
      pps_previous  <= 1'b0;
      loaded_hour   <= '0;
      loaded_minute <= '0;
      loaded_second <= '0;
    end else if (accept) begin
      if (item.operation == OP_LOAD) begin
        loaded_hour   <= item.gps_hour;
        loaded_minute <= item.gps_minute;
        loaded_second <= item.gps_second;
      end else begin
        millis_count <= millis_next;
        second_count <= second_next;
        minute_count <= minute_next;
        hour_count   <= hour_next;
        pps_previous <= item.pps_level;
        if (sync) begin
          loaded_second <= '0;
        end
      end
    end
  end

  // multiply-accumulate operand and product
  always_comb begin
    unique case (mac_step)
      MAC_HOUR:   mac_operand = MAC_OP_W'(hour_count);
      MAC_MINUTE: mac_operand = MAC_OP_W'(minute_count);
      default:    mac_operand = MAC_OP_W'(second_count);
    endcase
    mac_product = MAC_PROD_W'(mac_operand) * MAC_PROD_W'(mac_weight(mac_step));
    mac_acc     = (mac_step == MAC_HOUR) ? '0 : day_base_ms;
  end

  // day base rebuild, one weighted term per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      day_base_ms <= '0;
      mac_step    <= MAC_HOUR;
    end else if (accept) begin
      mac_step <= MAC_HOUR;
    end else if (mac_en) begin
      day_base_ms <= mac_acc + mac_product[DAY_W-1:0];
      mac_step    <= mac_step + 1'b1;
    end
  end

  // phase from the remainder unit
  assign sum = SUM_W'(day_base_ms) + SUM_W'(millis_count);

  assign mod_req.start    = mod_start;
  assign mod_req.dividend = sum;
  assign mod_req.divisor  = cycle_length;

  gsfpt_mod_unit u_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  // zero cycle length wraps at the phase width
  assign phase_val = (cycle_length == '0) ? sum[PHASE_W-1:0] : mod_rsp.remainder;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_phase <= '0;
      last_lamp  <= 1'b0;
    end else if (phase_wr) begin
      last_phase <= phase_val;
      last_lamp  <= (phase_val < on_duty);
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (item.operation == OP_LOAD) begin
            state_next = ST_EMIT;
          end else if (millis_next == '0) begin
            state_next = ST_MAC;
          end else begin
            state_next = ST_LAUNCH;
          end
        end
      end
      ST_MAC: begin
        if (mac_step == MAC_SECOND) begin
          state_next = ST_LAUNCH;
        end
      end
      ST_LAUNCH: state_next = ST_DIV;
      ST_DIV: begin
        if (mod_rsp.done) begin
          state_next = ST_PHASE;
        end
      end
      ST_PHASE: state_next = ST_EMIT;
      ST_EMIT: begin
        if (!out_valid || result.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    item_ready = 1'b0;
    mac_en     = 1'b0;
    mod_start  = 1'b0;
    phase_wr   = 1'b0;
    emit       = 1'b0;
    unique case (state)
      ST_IDLE:   item_ready = 1'b1;
      ST_MAC:    mac_en     = 1'b1;
      ST_LAUNCH: mod_start  = 1'b1;
      ST_DIV:    ;
      ST_PHASE:  phase_wr   = 1'b1;
      ST_EMIT:   emit       = !out_valid || result.ready;
      default:   ;
    endcase
  end

  assign item.ready = item_ready;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_lamp   <= last_lamp;
      out_phase  <= last_phase;
      out_hour   <= hour_count;
      out_minute <= minute_count;
      out_second <= second_count;
      out_millis <= millis_count;
    end
  end

  assign result.valid        = out_valid;
  assign result.lamp_on      = out_lamp;
  assign result.phase_ms     = out_phase;
  assign result.clock_hour   = out_hour;
  assign result.clock_minute = out_minute;
  assign result.clock_second = out_second;
  assign result.clock_millis = out_millis;

  `GSFPT_ASSERT_IMP(a_millis_range, clk, rst, 1'b1, millis_count <= MS_LAST, "bad millis")
  `GSFPT_ASSERT_IMP(a_sec_range, clk, rst, 1'b1, {1'b0, second_count} < SEC_PER_MIN, "bad second")
  `GSFPT_ASSERT_IMP(a_idle_unit, clk, rst, state == ST_IDLE, !mod_rsp.busy, "unit busy in idle")

endmodule

`default_nettype wire

### hdl/gsfpt_mod_unit.sv
// ----------------------------------------------------------------------------
// gsfpt_mod_unit
// restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
`include "gps_synced_flash_phase_timer_unit_assert.svh"

module gsfpt_mod_unit
  import gsfpt_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire gsfpt_mod_req_t req,
  output gsfpt_mod_rsp_t      rsp
);

  logic               busy;
  logic               done;
  logic [CNT_W-1:0]   cnt;
  logic [SUM_W-1:0]   dvd;
  logic [PHASE_W-1:0] dvs;
  logic [PHASE_W-1:0] rem;

  logic [PHASE_W:0]   trial;
  logic [PHASE_W:0]   diff;
  logic [PHASE_W-1:0] rem_next;

  // one compare and subtract step
  always_comb begin
    trial = {rem, dvd[SUM_W-1]};
    diff  = trial - {1'b0, dvs};
    if (trial >= {1'b0, dvs}) begin
      rem_next = diff[PHASE_W-1:0];
    end else begin
      rem_next = trial[PHASE_W-1:0];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dvs <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[SUM_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  assign rsp.busy      = busy;
  assign rsp.done      = done;
  assign rsp.remainder = rem;

  `GSFPT_ASSERT_IMP(a_start_idle, clk, rst, req.start, !busy, "start while busy")
  `GSFPT_ASSERT_IMP(a_rem_range, clk, rst, done && (dvs != '0), rem < dvs, "remainder out of range")
  `GSFPT_ASSERT_NXT(a_done_pulse, clk, rst, done, !done && !busy, "done not a single pulse")

endmodule

`default_nettype wire

### tb/gsfpt_tb_pkg.sv
// ----------------------------------------------------------------------------
// gsfpt_tb_pkg
// transaction types and scoreboard for the flash phase timer testbench
// ----------------------------------------------------------------------------
package gsfpt_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import gsfpt_pkg::*;

  // one input transaction
  typedef struct packed {
    logic              operation;
    logic              pps_level;
    logic [HOUR_W-1:0] gps_hour;
    logic [MIN_W-1:0]  gps_minute;
    logic [SEC_W-1:0]  gps_second;
  } flash_item_t;

  // one result transaction
  typedef struct packed {
    logic               lamp_on;
    logic [PHASE_W-1:0] phase_ms;
    logic [HOUR_W-1:0]  clock_hour;
    logic [MIN_W-1:0]   clock_minute;
    logic [SEC_W-1:0]   clock_second;
    logic [MS_W-1:0]    clock_millis;
  } flash_result_t;

  class flash_phase_scoreboard;
    // register copies
    logic [CFG_W-1:0]   cycle_len;
    logic [CFG_W-1:0]   on_duty;
    // kept clock
    logic [MS_W-1:0]    millis;
    logic [SEC_W-1:0]   second;
    logic [MIN_W-1:0]   minute;
    logic [HOUR_W-1:0]  hour;
    logic [DAY_W-1:0]   day_base;
    logic               pps_prev;
    // stored gps time
    logic [HOUR_W-1:0]  ld_hour;
    logic [MIN_W-1:0]   ld_minute;
    logic [SEC_W-1:0]   ld_second;
    // last flash output
    logic [PHASE_W-1:0] phase;
    logic               lamp;

    flash_result_t pending_results[$];
    int errors;

    function new();
      cycle_len = CYCLE_LENGTH_RESET;
      on_duty   = ON_DUTY_RESET;
      millis    = '0;
      second    = '0;
      minute    = '0;
      hour      = '0;
      day_base  = '0;
      pps_prev  = 1'b0;
      ld_hour   = '0;
      ld_minute = '0;
      ld_second = '0;
      phase     = '0;
      lamp      = 1'b0;
      errors    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
      case (index)
        REG_CYCLE_LENGTH: cycle_len = data;
        REG_ON_DUTY:      on_duty = data;
        default: ;
      endcase
    endfunction

    // one millisecond step, each wrap test is greater-or-equal
    function void advance_millis();
      logic [MS_W:0]   ms_n;
      logic [SEC_W:0]  s_n;
      logic [MIN_W:0]  m_n;
      logic [HOUR_W:0] h_n;
      ms_n = {1'b0, millis} + 1'b1;
      if (ms_n >= MS_PER_SEC) begin
        millis = '0;
        s_n = {1'b0, second} + 1'b1;
        if (s_n >= SEC_PER_MIN) begin
          second = '0;
          m_n = {1'b0, minute} + 1'b1;
          if (m_n >= MIN_PER_HOUR) begin
            minute = '0;
            h_n = {1'b0, hour} + 1'b1;
            hour = (h_n >= HOURS_PER_DAY) ? '0 : h_n[HOUR_W-1:0];
          end else begin
            minute = m_n[MIN_W-1:0];
          end
        end else begin
          second = s_n[SEC_W-1:0];
        end
      end else begin
        millis = ms_n[MS_W-1:0];
      end
    endfunction

    // work out the result of an accepted item and queue it
    function void log_item(flash_item_t it);
      logic               rising;
      logic [31:0]        base;
      logic [SUM_W-1:0]   sum;
      flash_result_t      r;
      if (it.operation == OP_LOAD) begin
        ld_hour   = it.gps_hour;
        ld_minute = it.gps_minute;
        ld_second = it.gps_second;
      end else begin
        rising   = it.pps_level && !pps_prev;
        pps_prev = it.pps_level;
        // pps edge with a stored :59 second jumps to the stored time
        if (rising && ld_second == SYNC_SECOND) begin
          millis    = MS_LAST;
          second    = ld_second;
          minute    = ld_minute;
          hour      = ld_hour;
          ld_second = '0;
        end
        advance_millis();
        if (millis == '0) begin
          base = 32'(hour) * 32'(WGT_HOUR) + 32'(minute) * 32'(WGT_MINUTE)
               + 32'(second) * 32'(WGT_SECOND);
          day_base = base[DAY_W-1:0];
        end
        sum = SUM_W'(day_base) + SUM_W'(millis);
        // zero cycle length behaves as a 65536 ms cycle
        if (cycle_len == '0)
          phase = sum[PHASE_W-1:0];
        else
          phase = PHASE_W'(sum % SUM_W'(cycle_len));
        lamp = (phase < on_duty);
      end
      r.lamp_on      = lamp;
      r.phase_ms     = phase;
      r.clock_hour   = hour;
      r.clock_minute = minute;
      r.clock_second = second;
      r.clock_millis = millis;
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        if (errors < 100)
          $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(flash_result_t got);
      flash_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors < 100)
          $display("%0t: unexpected result: expected none, actual %p", $time, got);
        return;
      end
      want = pending_results.pop_front();
      compare_field("lamp_on", want.lamp_on, got.lamp_on);
      compare_field("phase_ms", want.phase_ms, got.phase_ms);
      compare_field("clock_hour", want.clock_hour, got.clock_hour);
      compare_field("clock_minute", want.clock_minute, got.clock_minute);
      compare_field("clock_second", want.clock_second, got.clock_second);
      compare_field("clock_millis", want.clock_millis, got.clock_millis);
    endfunction
  endclass

endpackage

### tb/tb_gps_synced_flash_phase_timer_unit.sv
// ----------------------------------------------------------------------------
// tb_gps_synced_flash_phase_timer_unit
// drives tick and gps load transactions through the flash phase timer under
// several register settings and idle patterns, checking every result against
// a cycle-free model of the kept clock, day base and flash phase
// ----------------------------------------------------------------------------
module tb_gps_synced_flash_phase_timer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import gsfpt_pkg::*;
  import gsfpt_tb_pkg::*;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 135;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 40;
  localparam int CYCLE_LIMIT     = 1000000;

  logic clk;
  logic rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  gsfpt_item_if   item_ch ();
  gsfpt_result_if result_ch ();

  flash_phase_scoreboard sb = new();

  int sender_pct;
  int receiver_pct;
  bit hold_req;
  int phase_items;
  int cycles;

  gps_synced_flash_phase_timer_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .result    (result_ch)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  // result ready, with random stalls and one long hold-off on request
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        result_ch.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        result_ch.ready = !($urandom_range(99) < receiver_pct);
      end
    end
  end

  // result monitor
  initial begin : result_monitor
    flash_result_t got;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) begin
        got.lamp_on      = result_ch.lamp_on;
        got.phase_ms     = result_ch.phase_ms;
        got.clock_hour   = result_ch.clock_hour;
        got.clock_minute = result_ch.clock_minute;
        got.clock_second = result_ch.clock_second;
        got.clock_millis = result_ch.clock_millis;
        sb.check_result(got);
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = index;
    cfg_data  = data;
    sb.write_reg(index, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // offer one transaction, with a random gap first, and wait for acceptance
  task automatic send_item(flash_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_pct && gap < 200) gap++;
    @(negedge clk);
    if (gap > 0) begin
      item_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid      = 1'b1;
    item_ch.operation  = it.operation;
    item_ch.pps_level  = it.pps_level;
    item_ch.gps_hour   = it.gps_hour;
    item_ch.gps_minute = it.gps_minute;
    item_ch.gps_second = it.gps_second;
    do @(posedge clk); while (!item_ch.ready);
    sb.log_item(it);
    phase_items++;
  endtask

  task automatic send_tick(logic pps);
    flash_item_t it;
    it.operation  = OP_TICK;
    it.pps_level  = pps;
    it.gps_hour   = HOUR_W'($urandom);
    it.gps_minute = MIN_W'($urandom);
    it.gps_second = SEC_W'($urandom);
    send_item(it);
  endtask

  // load carries a random pps level, which must be ignored
  task automatic send_load(logic [HOUR_W-1:0] h, logic [MIN_W-1:0] m, logic [SEC_W-1:0] s);
    flash_item_t it;
    it.operation  = OP_LOAD;
    it.pps_level  = 1'($urandom);
    it.gps_hour   = h;
    it.gps_minute = m;
    it.gps_second = s;
    send_item(it);
  endtask

  // load a time, raise pps, then run on with pps high for a random stretch, then low
  task automatic send_sync_burst();
    logic [HOUR_W-1:0] h;
    logic [MIN_W-1:0]  m;
    logic [SEC_W-1:0]  s;
    int lead;
    int run;
    int high_len;
    h = ($urandom_range(99) < 80) ? HOUR_W'($urandom_range(23)) : HOUR_W'($urandom_range(31));
    m = ($urandom_range(99) < 80) ? MIN_W'($urandom_range(59)) : MIN_W'($urandom_range(63));
    s = ($urandom_range(99) < 85) ? SYNC_SECOND : SEC_W'($urandom_range(63));
    send_load(h, m, s);
    lead = $urandom_range(2);
    repeat (lead) send_tick(1'b0);
    send_tick(1'b1);
    run = $urandom_range(40);
    high_len = $urandom_range(run);
    for (int i = 0; i < run; i++) send_tick(i < high_len);
  endtask

  // fully random transactions
  task automatic send_noise();
    flash_item_t it;
    repeat ($urandom_range(1, 8)) begin
      it.operation  = $urandom_range(1) ? OP_LOAD : OP_TICK;
      it.pps_level  = 1'($urandom);
      it.gps_hour   = HOUR_W'($urandom);
      it.gps_minute = MIN_W'($urandom);
      it.gps_second = SEC_W'($urandom);
      send_item(it);
    end
  endtask

  // main sequence
  initial begin
    int cyc;
    int duty;
    idle_mode_t mode;

    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    item_ch.valid      = 1'b0;
    item_ch.operation  = OP_TICK;
    item_ch.pps_level  = 1'b0;
    item_ch.gps_hour   = '0;
    item_ch.gps_minute = '0;
    item_ch.gps_second = '0;
    sender_pct         = 0;
    receiver_pct       = 0;
    hold_req           = 1'b0;
    phase_items        = 0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: day wrap, no-sync cases, out of range loads, pps edges
    send_tick(1'b0);
    send_load(5'd23, 6'd59, 6'd59);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_load(5'd31, 6'd63, 6'd63);
    send_tick(1'b0);
    send_tick(1'b1);
    send_load(5'd31, 6'd63, 6'd59);
    send_tick(1'b0);
    send_tick(1'b1);
    send_load(5'd30, 6'd10, 6'd59);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    send_load(5'd0, 6'd0, 6'd0);
    send_tick(1'b0);
    send_load(5'd12, 6'd34, 6'd59);
    send_tick(1'b1);
    send_tick(1'b1);

    // random phases, each with its own register setting and idle pattern
    for (int p = 0; p < NUM_PHASES; p++) begin
      @(negedge clk);
      item_ch.valid = 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clk);
      case (p)
        0: begin cyc = 1000;  duty = 500;   end
        1: begin cyc = 1;     duty = 0;     end
        2: begin cyc = 65535; duty = 65535; end
        3: begin cyc = 0;     duty = 32768; end
        4: begin cyc = 7;     duty = 3;     end
        6: begin cyc = 60000; duty = 1;     end
        default: begin
          cyc  = $urandom_range(65535);
          duty = $urandom_range(cyc);
        end
      endcase
      write_reg(REG_CYCLE_LENGTH, CFG_W'(cyc));
      write_reg(REG_ON_DUTY, CFG_W'(duty));
      mode = idle_mode_t'(p % 4);
      case (mode)
        IDLE_NONE:     begin sender_pct = 0;  receiver_pct = 0;  end
        IDLE_SENDER:   begin sender_pct = 64; receiver_pct = 0;  end
        IDLE_RECEIVER: begin sender_pct = 0;  receiver_pct = 64; end
        default:       begin sender_pct = 9;  receiver_pct = 9;  end
      endcase
      // long receiver hold-off while items keep coming
      if (p == 0)
        hold_req = 1'b1;
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
        if ($urandom_range(99) < 75)
          send_sync_burst();
        else
          send_noise();
      end
    end

    // drain
    @(negedge clk);
    item_ch.valid = 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
